// ===== design/max_rectangle_binary_matrix_macros.svh =====
// ----------------------------------------------------------------------------
// max_rectangle_binary_matrix_macros
// Assertion helpers for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef MAX_RECTANGLE_BINARY_MATRIX_MACROS_SVH
`define MAX_RECTANGLE_BINARY_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MRBM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrbm assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MRBM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrbm assertion failed");

`endif

// ===== design/mrbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrbm_pkg
// Shared types and fixed constants of the max-rectangle block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrbm_pkg;

    localparam int CFG_W    = 7;
    localparam int AREA_W   = 13;
    localparam int IN_TD_W  = 8;
    localparam int OUT_TD_W = 16;

    localparam logic [CFG_W-1:0]  COLS_RESET = 7'd64;
    localparam logic [AREA_W-1:0] AREA_MAX   = 13'd8191;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_POP,
        S_POP_LOAD,
        S_FLUSH,
        S_FLUSH_LOAD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic note_en;
        logic clear_best;
    } area_ctl_t;

endpackage

`default_nettype wire

// ===== design/mrbm_ram.sv =====
// ----------------------------------------------------------------------------
// mrbm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/mrbm_area.sv =====
// ----------------------------------------------------------------------------
// mrbm_area
// Rectangle area multiply, saturation and running best area.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbm_area
    import mrbm_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire area_ctl_t                     ctl,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0] height,
    input  wire logic [$clog2(MAX_COLS+1)-1:0] width,
    output logic      [AREA_W-1:0]             best
);

    localparam int HW     = $clog2(MAX_ROWS + 1);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int PROD_W = HW + CNT_W;
    localparam int EXT_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W;

    logic [PROD_W-1:0] prod_reg;
    logic [EXT_W-1:0]  prod_ext;
    logic [AREA_W-1:0] area_sat;
    logic [AREA_W-1:0] best_reg;
    logic [AREA_W-1:0] best_next;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_W'(height) * PROD_W'(width);
        end
    end

    always_comb
    begin
        prod_ext = EXT_W'(prod_reg);
        if (prod_ext > EXT_W'(AREA_MAX))
        begin
            area_sat = AREA_MAX;
        end
        else
        begin
            area_sat = prod_ext[AREA_W-1:0];
        end

        best_next = best_reg;
        if (ctl.clear_best)
        begin
            best_next = '0;
        end
        else if (ctl.note_en && (area_sat > best_reg))
        begin
            best_next = area_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

`default_nettype wire

// ===== design/max_rectangle_binary_matrix.sv =====
// ----------------------------------------------------------------------------
// max_rectangle_binary_matrix
// Largest all-ones rectangle of a streamed binary matrix.
// ----------------------------------------------------------------------------
// Cells enter one request at a time in row-major order on the slave stream
// (tdata[0] = cell, tlast = final cell of the matrix); cols_in_use, written
// through cfg_wr_en/cfg_wr_data, sets the row width (0 acts as 1, values above
// MAX_COLS act as MAX_COLS). Column heights sit in one RAM and the histogram
// stack in a second RAM, both with a registered read. A cell passes through
// accept, height read-modify-write and push, with a pop and a load step per
// stack pop; a row end adds a flush step plus a pop and a load step per bar
// still on the stack. Each pop needs its load step because of the stack RAM
// registered read: the new top of stack is known only the cycle after a pop.
// After reset and after every final cell a pass over all MAX_COLS entries
// zeroes the height RAM; no cell is taken during it (configuration writes are
// still taken). The result sits in an output register, so cells of the next
// matrix are taken while it waits; only a second final cell stalls on it.
// ----------------------------------------------------------------------------
`default_nettype none

module max_rectangle_binary_matrix
    import mrbm_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // slave stream: tdata[0] = cell_req, tdata[7:1] = zero; tlast = last_cell
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_TD_W-1:0]   s_axis_tdata,
    input  wire logic                 s_axis_tlast,
    // master stream: tdata[12:0] = largest area, tdata[15:13] = zero
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [OUT_TD_W-1:0]  m_axis_tdata,
    // cols_in_use register write
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int ENT_W = IDX_W + CNT_W + HW;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // control state
    state_t              state_reg,    state_next;
    logic [IDX_W-1:0]    clr_cnt_reg,  clr_cnt_next;
    logic [IDX_W-1:0]    pos_reg,      pos_next;
    logic [CNT_W-1:0]    depth_reg,    depth_next;
    logic [CFG_W-1:0]    cols_reg;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic                cell_reg,     cell_next;
    logic                last_reg,     last_next;
    logic [HW-1:0]       h_reg,        h_next;
    logic [IDX_W-1:0]    top_idx_reg,  top_idx_next;
    logic [CNT_W-1:0]    top_left_reg, top_left_next;
    logic [HW-1:0]       top_h_reg,    top_h_next;
    logic [AREA_W-1:0]   out_area_reg, out_area_next;

    // height RAM
    logic                hram_we;
    logic [IDX_W-1:0]    hram_waddr;
    logic [HW-1:0]       hram_wdata;
    logic                hram_re;
    logic [HW-1:0]       hram_rdata;

    // stack RAM: entries below the top of stack, {idx, left, height}
    logic                sram_we;
    logic [IDX_W-1:0]    sram_waddr;
    logic [ENT_W-1:0]    sram_wdata;
    logic                sram_re;
    logic [IDX_W-1:0]    sram_raddr;
    logic [ENT_W-1:0]    sram_rdata;

    // area unit
    area_ctl_t           area_ctl;
    logic [HW-1:0]       area_height;
    logic [CNT_W-1:0]    area_width;
    logic [AREA_W-1:0]   best_area;

    logic [CNT_W-1:0]    cols_eff;
    logic [CNT_W-1:0]    pos_plus1;
    logic                row_end;
    logic                in_accept;
    logic                out_accept;

    // effective row width, clamped to 1..MAX_COLS
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (CMP_W'(cols_reg) > CMP_W'(MAX_COLS))
        begin
            cols_eff = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNT_W'(cols_reg);
        end
    end

    assign pos_plus1  = CNT_W'(pos_reg) + CNT_W'(1);
    assign row_end    = (pos_plus1 >= cols_eff) || last_reg;
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pos_next       = pos_reg;
        depth_next     = depth_reg;
        out_valid_next = out_valid_reg && !out_accept;
        cell_next      = cell_reg;
        last_next      = last_reg;
        h_next         = h_reg;
        top_idx_next   = top_idx_reg;
        top_left_next  = top_left_reg;
        top_h_next     = top_h_reg;
        out_area_next  = out_area_reg;

        s_axis_tready  = 1'b0;
        hram_we        = 1'b0;
        hram_waddr     = pos_reg;
        hram_wdata     = h_reg;
        hram_re        = 1'b0;
        sram_we        = 1'b0;
        sram_waddr     = IDX_W'(depth_reg - CNT_W'(1));
        sram_wdata     = {top_idx_reg, top_left_reg, top_h_reg};
        sram_re        = 1'b0;
        sram_raddr     = IDX_W'(depth_reg - CNT_W'(2));
        area_ctl       = '0;
        area_height    = top_h_reg;
        area_width     = CNT_W'(pos_reg) - top_left_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // zero one height per cycle
                hram_we    = 1'b1;
                hram_waddr = clr_cnt_reg;
                hram_wdata = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(MAX_COLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                hram_re       = 1'b1;
                if (in_accept)
                begin
                    cell_next  = s_axis_tdata[0];
                    last_next  = s_axis_tlast;
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                // height read-modify-write, saturating at MAX_ROWS
                if (!cell_reg)
                begin
                    h_next = '0;
                end
                else if (hram_rdata < HW'(MAX_ROWS))
                begin
                    h_next = hram_rdata + HW'(1);
                end
                else
                begin
                    h_next = HW'(MAX_ROWS);
                end
                hram_we    = 1'b1;
                hram_wdata = h_next;
                state_next = S_POP;
            end

            S_POP:
            begin
                if ((depth_reg != '0) && (top_h_reg >= h_reg))
                begin
                    // pop a bar no lower than the new one, right bound = pos
                    area_ctl.mul_en = 1'b1;
                    sram_re    = (depth_reg >= CNT_W'(2));
                    depth_next = depth_reg - CNT_W'(1);
                    state_next = S_POP_LOAD;
                end
                else
                begin
                    // push: the old top goes to RAM, the new bar into registers
                    sram_we       = (depth_reg != '0);
                    top_idx_next  = pos_reg;
                    top_left_next = (depth_reg != '0) ?
                                    (CNT_W'(top_idx_reg) + CNT_W'(1)) : '0;
                    top_h_next    = h_reg;
                    depth_next    = depth_reg + CNT_W'(1);
                    if (row_end)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        pos_next   = pos_reg + IDX_W'(1);
                        state_next = S_IDLE;
                    end
                end
            end

            S_POP_LOAD, S_FLUSH_LOAD:
            begin
                area_ctl.note_en = 1'b1;
                if (depth_reg != '0)
                begin
                    {top_idx_next, top_left_next, top_h_next} = sram_rdata;
                end
                state_next = (state_reg == S_POP_LOAD) ? S_POP : S_FLUSH;
            end

            S_FLUSH:
            begin
                // end of row: empty the stack, right bound = pos + 1
                area_width = pos_plus1 - top_left_reg;
                if (depth_reg != '0)
                begin
                    area_ctl.mul_en = 1'b1;
                    sram_re    = (depth_reg >= CNT_W'(2));
                    depth_next = depth_reg - CNT_W'(1);
                    state_next = S_FLUSH_LOAD;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = last_reg ? S_DONE : S_IDLE;
                end
            end

            S_DONE:
            begin
                // hand the best area to the output register once it is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_area_next       = best_area;
                    out_valid_next      = 1'b1;
                    area_ctl.clear_best = 1'b1;
                    clr_cnt_next        = '0;
                    state_next          = S_CLEAR;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            cols_reg      <= COLS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pos_reg       <= pos_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cols_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg     <= cell_next;
        last_reg     <= last_next;
        h_reg        <= h_next;
        top_idx_reg  <= top_idx_next;
        top_left_reg <= top_left_next;
        top_h_reg    <= top_h_next;
        out_area_reg <= out_area_next;
    end

    mrbm_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_COLS)
    ) u_height_ram (
        .clk   (clk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .re    (hram_re),
        .raddr (pos_reg),
        .rdata (hram_rdata)
    );

    mrbm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_COLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .re    (sram_re),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    mrbm_area #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_area (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (area_ctl),
        .height (area_height),
        .width  (area_width),
        .best   (best_area)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TD_W'(out_area_reg);

endmodule

`default_nettype wire

// ===== design/mrbm_checker.sv =====
// ----------------------------------------------------------------------------
// mrbm_checker
// Port-level checks of the max-rectangle block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_rectangle_binary_matrix_macros.svh"

module mrbm_checker
    import mrbm_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                s_axis_tlast,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OUT_TD_W-1:0] m_axis_tdata
);

    localparam int FULL_AREA  = MAX_COLS * MAX_ROWS;
    localparam int AREA_BOUND = (FULL_AREA < int'(AREA_MAX)) ? FULL_AREA : int'(AREA_MAX);

    // a pending result is not withdrawn
    `MRBM_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // area never beyond the matrix size, padding bits zero
    `MRBM_ASSERT_IMP(a_area_bound, clk, rst_n, m_axis_tvalid, (m_axis_tdata[12:0] <= 13'(AREA_BOUND)) && (m_axis_tdata[15:13] == 3'd0))

    // one cell in flight: a request is never taken in the cycle after another
    `MRBM_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a final cell leads into the height clearing pass and keeps the input busy
    `MRBM_ASSERT_NXT(a_last_busy, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, ##1 !s_axis_tready)

endmodule

bind max_rectangle_binary_matrix mrbm_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
) u_mrbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
